@@ src/obd_prd_pkg.sv @@
// ----------------------------------------------------------------------------
// obd_prd_pkg
// Shared types, PID tables and helpers for the mode 01 PID response decoder.
// ----------------------------------------------------------------------------
package obd_prd_pkg;

	// requested PID slots
	localparam logic [2:0] SLOT_RPM      = 3'd0;
	localparam logic [2:0] SLOT_SPEED    = 3'd1;
	localparam logic [2:0] SLOT_THROTTLE = 3'd2;
	localparam logic [2:0] SLOT_LOAD     = 3'd3;
	localparam logic [2:0] SLOT_MAP      = 3'd4;
	localparam logic [2:0] SLOT_COOLANT  = 3'd5;
	localparam logic [2:0] SLOT_AIR_TEMP = 3'd6;
	localparam logic [2:0] SLOT_VOLTAGE  = 3'd7;

	// positive response header for mode 01
	localparam logic [7:0] RESP_MODE01 = 8'h41;

	// throttle/load percent: A*100 (exact part), /255 done with shifts
	localparam logic [7:0]  PCT_SCALE  = 8'd100;
	// voltage: floor(z/125) as (z*VOLT_RECIP) >> VOLT_SHIFT, exact for z < 2^21
	localparam int unsigned VOLT_SHIFT = 28;
	localparam logic [21:0] VOLT_RECIP = 22'd2147484;
	// temperature offset in degrees
	localparam logic signed [9:0] TEMP_OFFSET = 10'sd40;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic logic [7:0] pid_code(input logic [2:0] slot);
		logic [7:0] code;
		case (slot)
			SLOT_RPM:      code = 8'h0C;
			SLOT_SPEED:    code = 8'h0D;
			SLOT_THROTTLE: code = 8'h11;
			SLOT_LOAD:     code = 8'h04;
			SLOT_MAP:      code = 8'h0B;
			SLOT_COOLANT:  code = 8'h05;
			SLOT_AIR_TEMP: code = 8'h0F;
			SLOT_VOLTAGE:  code = 8'h42;
			default:       code = 8'h00;
		endcase
		return code;
	endfunction

	// number of data digits for a slot: two per data byte
	function automatic logic [2:0] pid_digits(input logic [2:0] slot);
		logic [2:0] n;
		case (slot)
			SLOT_RPM, SLOT_VOLTAGE: n = 3'd4;
			default:                n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		case (c) inside
			[8'h30:8'h39]: h.val = c[3:0];
			[8'h41:8'h46],
			[8'h61:8'h66]: h.val = 4'(c[2:0] + 3'd1) + 4'd8;
			default:       h.ok  = 1'b0;
		endcase
		return h;
	endfunction

endpackage

@@ src/obd_pid_response_decoder.sv @@
// ----------------------------------------------------------------------------
// obd_pid_response_decoder
// Scans a mode 01 response character stream for "41 <pid>", collects the data
// bytes and reports raw bytes plus the physical value in signed Q8.
// ----------------------------------------------------------------------------
//  channel | signals                               | dir | word
//  --------+---------------------------------------+-----+----------------------
//  in      | in_valid, in_stall, ch, pid_slot, last| in  | one response character
//  out     | out_valid, out_stall, found,          | out | one word per response,
//          | raw_data, value_q8                    |     | after the last char
//
// One character is accepted per cycle unless in_stall is high. Three register
// stages: input register, matcher/collector update with result capture, value
// scaling into the output register, whose out_valid marks each response result.
// arst_n clears all valid flags and the matcher state.
// A stalled output backs up through the stages into in_stall only when a last
// character has to park a result; other characters keep flowing.
// ----------------------------------------------------------------------------
module obd_pid_response_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	input  logic [2:0]         pid_slot,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [15:0]        raw_data,
	output logic signed [22:0] value_q8
);

	// stage 1: input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic [2:0] slot_s1;
	logic       last_s1;

	// matcher / collector state
	logic [11:0] recent_q, recent_n;
	logic [1:0]  seen_q, seen_n;
	logic        matched_q, matched_n;
	logic [2:0]  dcnt_q, dcnt_n;
	logic [15:0] accum_q, accum_n;

	// stage 2: captured result
	logic        valid_s2;
	logic        found_s2;
	logic [15:0] raw_s2;
	logic [2:0]  slot_s2;

	logic s1_go, s2_free, out_adv;
	logic found_n;
	logic [2:0] need;
	logic [15:0] window;
	obd_prd_pkg::hex_digit_t dig;

	assign out_adv  = !out_valid || !out_stall;
	assign s2_free  = !valid_s2 || out_adv;
	assign s1_go    = valid_s1 && (!last_s1 || s2_free);
	assign in_stall = valid_s1 && !s1_go;

	assign need   = obd_prd_pkg::pid_digits(slot_s1);
	assign dig    = obd_prd_pkg::hex_decode(ch_s1);
	assign window = {recent_q, dig.val};

	always_comb begin
		recent_n  = recent_q;
		seen_n    = seen_q;
		matched_n = matched_q;
		dcnt_n    = dcnt_q;
		accum_n   = accum_q;
		if (dig.ok) begin
			if (matched_q) begin
				if (dcnt_q < need) begin
					accum_n = {accum_q[11:0], dig.val};
					dcnt_n  = dcnt_q + 3'd1;
				end
			end else begin
				if (seen_q == 2'd3 &&
				    window == {obd_prd_pkg::RESP_MODE01, obd_prd_pkg::pid_code(slot_s1)}) begin
					matched_n = 1'b1;
					dcnt_n    = 3'd0;
					accum_n   = 16'd0;
				end
				recent_n = window[11:0];
				if (seen_q != 2'd3)
					seen_n = seen_q + 2'd1;
			end
		end
		found_n = matched_n && (dcnt_n == need);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_go) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1   <= ch;
			slot_s1 <= pid_slot;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q  <= 12'd0;
			seen_q    <= 2'd0;
			matched_q <= 1'b0;
			dcnt_q    <= 3'd0;
			accum_q   <= 16'd0;
		end else if (s1_go) begin
			if (last_s1) begin
				recent_q  <= 12'd0;
				seen_q    <= 2'd0;
				matched_q <= 1'b0;
				dcnt_q    <= 3'd0;
				accum_q   <= 16'd0;
			end else begin
				recent_q  <= recent_n;
				seen_q    <= seen_n;
				matched_q <= matched_n;
				dcnt_q    <= dcnt_n;
				accum_q   <= accum_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			found_s2 <= found_n;
			raw_s2   <= found_n ? accum_n : 16'd0;
			slot_s2  <= slot_s1;
		end
	end

	// value scaling
	logic [7:0]         a_byte;
	logic [14:0]        pct_lo;
	logic [14:0]        pct_lo1;
	logic [15:0]        pct_val;
	logic [20:0]        volt_z;
	logic [42:0]        volt_prod;
	logic signed [9:0]  temp_c;
	logic signed [22:0] value_n;

	assign a_byte    = raw_s2[7:0];
	assign pct_lo    = 15'(a_byte) * 15'(obd_prd_pkg::PCT_SCALE);
	assign pct_lo1   = pct_lo + 15'd1;
	// A*25600/255 = 100*A + floor(100*A/255)
	assign pct_val   = 16'(pct_lo) + 16'((16'(pct_lo1) + 16'(pct_lo1[14:8])) >> 8);
	assign volt_z    = {raw_s2, 5'b0};
	assign volt_prod = 43'(volt_z) * 43'(obd_prd_pkg::VOLT_RECIP);
	assign temp_c    = $signed({2'b00, a_byte}) - obd_prd_pkg::TEMP_OFFSET;

	always_comb begin
		case (slot_s2)
			obd_prd_pkg::SLOT_RPM:
				value_n = $signed({1'b0, raw_s2, 6'b0});
			obd_prd_pkg::SLOT_THROTTLE, obd_prd_pkg::SLOT_LOAD:
				value_n = $signed({7'b0, pct_val});
			obd_prd_pkg::SLOT_COOLANT, obd_prd_pkg::SLOT_AIR_TEMP:
				value_n = $signed({{5{temp_c[9]}}, temp_c, 8'b0});
			obd_prd_pkg::SLOT_VOLTAGE:
				value_n = $signed({8'b0, volt_prod[42:obd_prd_pkg::VOLT_SHIFT]});
			default:
				value_n = $signed({raw_s2[14:0], 8'b0});
		endcase
		if (!found_s2)
			value_n = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_adv) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			found    <= found_s2;
			raw_data <= raw_s2;
			value_q8 <= value_n;
		end
	end

	// ------------------------------------------------------------------------
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> raw_data == 16'd0 && value_q8 == 23'sd0)
		else $error("miss word carries nonzero data");

	a_match_after_three: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q |-> seen_q == 2'd3)
		else $error("prefix matched before four digits");

	a_dcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= 3'd4 && (matched_q || dcnt_q == 3'd0))
		else $error("data digit count out of range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && valid_s2 && out_valid)
		else $error("input stalled without a parked result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> !matched_q && seen_q == 2'd0 && accum_q == 16'd0)
		else $error("state not cleared after last character");

endmodule

@@ sim/obd_pid_response_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pid_response_decoder_tb
// Drives mode 01 response text one character per word and checks every result
// word against an in-bench decoder or typed table values. A short list of
// directed responses comes first, then random responses, mostly well formed
// with random noise, four sender/receiver idle mixes and one long output hold.
// ----------------------------------------------------------------------------
module obd_pid_response_decoder_tb;

	localparam int RANDOM_ITEMS = 760;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;
	// PID codes packed by slot, slot 0 in the low byte
	localparam logic [63:0] PID_CODES = 64'h42_0F_05_0B_04_11_0D_0C;

	typedef struct packed {
		logic        found;
		logic [15:0] raw;
		logic [22:0] val;
	} pid_result_t;

	typedef struct {
		string       text;
		logic [2:0]  slot;
		logic [2:0]  slot_at_last;
		bit          typed;
		logic        found;
		logic [15:0] raw;
		int          val;
	} direct_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [7:0]         ch        = 8'h00;
	logic [2:0]         pid_slot  = obd_prd_pkg::SLOT_RPM;
	logic               last      = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               found;
	logic [15:0]        raw_data;
	logic signed [22:0] value_q8;

	// decoder state mirrored in the bench
	logic [11:0] dig_hist;
	logic [1:0]  dig_cnt;
	logic        pfx_hit;
	logic [2:0]  data_cnt;
	logic [15:0] data_acc;

	pid_result_t expected_results[$];
	direct_row_t directed[$];
	logic [7:0]  resp_text[$];

	int errors        = 0;
	int words_sent    = 0;
	int responses     = 0;
	int results_seen  = 0;
	int found_seen    = 0;
	int quiet_cycles  = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_seq      = 0;
	int hold_ack      = 0;
	int hold_left     = 0;

	obd_pid_response_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.pid_slot  (pid_slot),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.raw_data  (raw_data),
		.value_q8  (value_q8)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic logic [2:0] digits_needed(input logic [2:0] s);
		return (s == obd_prd_pkg::SLOT_RPM || s == obd_prd_pkg::SLOT_VOLTAGE) ? 3'd4 : 3'd2;
	endfunction

	function automatic logic [22:0] scale_q8(input logic [2:0] s, input logic [15:0] raw);
		int unsigned r = 32'(raw);
		int v;
		case (s)
			obd_prd_pkg::SLOT_RPM:
				v = r * 64;
			obd_prd_pkg::SLOT_THROTTLE, obd_prd_pkg::SLOT_LOAD:
				v = (r * 25600) / 255;
			obd_prd_pkg::SLOT_COOLANT, obd_prd_pkg::SLOT_AIR_TEMP:
				v = (int'(r) - 40) * 256;
			obd_prd_pkg::SLOT_VOLTAGE:
				v = (r * 256) / 1000;
			default:
				v = r * 256;
		endcase
		return v[22:0];
	endfunction

	// advance the mirrored matcher by one word; returns 1 when a result is due
	function automatic bit decode_step(input logic [7:0] c, input logic [2:0] s,
			input logic l, output pid_result_t res);
		int d = nibble_of(c);
		logic [2:0] need = digits_needed(s);
		logic [15:0] win;
		res = '0;
		if (d >= 0) begin
			if (pfx_hit) begin
				if (data_cnt < need) begin
					data_acc = {data_acc[11:0], 4'(d)};
					data_cnt++;
				end
			end else begin
				win = {dig_hist, 4'(d)};
				if (dig_cnt == 2'd3 &&
				    win == {obd_prd_pkg::RESP_MODE01, PID_CODES[s*8 +: 8]}) begin
					pfx_hit  = 1'b1;
					data_cnt = 3'd0;
					data_acc = 16'h0;
				end
				dig_hist = win[11:0];
				if (dig_cnt != 2'd3) dig_cnt++;
			end
		end
		if (!l) return 1'b0;
		res.found = pfx_hit && data_cnt == need;
		if (res.found) begin
			res.raw = data_acc;
			res.val = scale_q8(s, data_acc);
		end
		dig_hist = 12'h0;
		dig_cnt  = 2'd0;
		pfx_hit  = 1'b0;
		data_cnt = 3'd0;
		data_acc = 16'h0;
		return 1'b1;
	endfunction

	function automatic void report_fail(input string msg);
		errors++;
		if (errors <= 10) $display("%s", msg);
	endfunction

	function automatic logic [7:0] filler();
		logic [7:0] c;
		if ($urandom_range(1)) return " ";
		do c = 8'($urandom_range(255)); while (nibble_of(c) >= 0);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) return "0" + n;
		return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
	endfunction

	function automatic void push_hex_byte(input logic [7:0] b);
		resp_text.push_back(hex_char(b[7:4]));
		resp_text.push_back(hex_char(b[3:0]));
		if ($urandom_range(2) != 0) resp_text.push_back(filler());
	endfunction

	task automatic send_char(input logic [7:0] c, input logic [2:0] s, input logic l,
			input bit use_typed, input pid_result_t typed);
		pid_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		pid_slot <= s;
		last     <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		if (decode_step(c, s, l, res)) begin
			expected_results.push_back(use_typed ? typed : res);
			responses++;
		end
	endtask

	task automatic send_random_response();
		logic [2:0]  s = 3'($urandom_range(7));
		logic [2:0]  s_last;
		int          kind = $urandom_range(99);
		int          ndig;
		logic [31:0] bits;
		logic [7:0]  code;
		resp_text.delete();
		s_last = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : s;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) resp_text.push_back(8'($urandom_range(255)));
		if (kind < 88) begin
			code = (kind >= 80) ? PID_CODES[$urandom_range(7)*8 +: 8] : PID_CODES[s*8 +: 8];
			push_hex_byte(obd_prd_pkg::RESP_MODE01);
			push_hex_byte(code);
			ndig = digits_needed(s);
			if (kind >= 70 && kind < 80) ndig = $urandom_range(0, ndig - 1);
			else if ($urandom_range(4) == 0) ndig += $urandom_range(1, 4);
			case ($urandom_range(5))
				0:       bits = 32'h0;
				1:       bits = 32'hFFFF_FFFF;
				default: bits = $urandom;
			endcase
			for (int i = 0; i < ndig; i++) begin
				resp_text.push_back(hex_char(bits[4*i +: 4]));
				if (i % 2 == 1 && $urandom_range(1)) resp_text.push_back(filler());
			end
		end else begin
			repeat ($urandom_range(1, 12)) resp_text.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(1)) resp_text.push_back($urandom_range(1) ? 8'h0D : filler());
		foreach (resp_text[i]) begin
			if (i == resp_text.size() - 1) send_char(resp_text[i], s_last, 1'b1, 1'b0, '0);
			else send_char(resp_text[i], s, 1'b0, 1'b0, '0);
		end
	endtask

	function automatic void add_row(input string text, input logic [2:0] s,
			input logic [2:0] s_last, input bit typed, input logic f,
			input logic [15:0] raw, input int val);
		direct_row_t row;
		row.text         = text;
		row.slot         = s;
		row.slot_at_last = s_last;
		row.typed        = typed;
		row.found        = f;
		row.raw          = raw;
		row.val          = val;
		directed.push_back(row);
	endfunction

	// receiver: random stall, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_seq != hold_ack) begin
			hold_ack  <= hold_seq;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		pid_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (found) found_seen++;
			if (expected_results.size() == 0) begin
				report_fail($sformatf("unexpected result word: found %0b raw %h value %0d",
					found, raw_data, value_q8));
			end else begin
				want = expected_results.pop_front();
				if (found !== want.found || raw_data !== want.raw || value_q8 !== want.val)
					report_fail($sformatf(
						"result %0d mismatch (exp/act): found %0b/%0b raw %h/%h value %0d/%0d",
						results_seen, want.found, found, want.raw, raw_data,
						$signed(want.val), value_q8));
			end
		end
	end

	// watchdog on cycles with no word accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
				$display("obd_pid_response_decoder_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		direct_row_t row;
		pid_result_t typed;
		int n;
		dig_hist = 12'h0;
		dig_cnt  = 2'd0;
		pfx_hit  = 1'b0;
		data_cnt = 3'd0;
		data_acc = 16'h0;

		add_row("410cffff", obd_prd_pkg::SLOT_RPM, obd_prd_pkg::SLOT_RPM,
			1, 1'b1, 16'hFFFF, 4194240);
		add_row("410D00", obd_prd_pkg::SLOT_SPEED, obd_prd_pkg::SLOT_SPEED,
			1, 1'b1, 16'h0000, 0);
		add_row("4111FF", obd_prd_pkg::SLOT_THROTTLE, obd_prd_pkg::SLOT_THROTTLE,
			1, 1'b1, 16'h00FF, 25600);
		add_row("410500", obd_prd_pkg::SLOT_COOLANT, obd_prd_pkg::SLOT_COOLANT,
			1, 1'b1, 16'h0000, -10240);
		add_row("4142FFFF", obd_prd_pkg::SLOT_VOLTAGE, obd_prd_pkg::SLOT_VOLTAGE,
			1, 1'b1, 16'hFFFF, 16776);
		add_row("4142", obd_prd_pkg::SLOT_VOLTAGE, obd_prd_pkg::SLOT_VOLTAGE,
			1, 1'b0, 16'h0000, 0);
		add_row("OK\r", obd_prd_pkg::SLOT_LOAD, obd_prd_pkg::SLOT_LOAD,
			1, 1'b0, 16'h0000, 0);
		add_row("410B7F.", obd_prd_pkg::SLOT_MAP, obd_prd_pkg::SLOT_MAP,
			1, 1'b1, 16'h007F, 32512);
		// prefix split across two responses must not match
		add_row("41", obd_prd_pkg::SLOT_SPEED, obd_prd_pkg::SLOT_SPEED,
			1, 1'b0, 16'h0000, 0);
		add_row("0D12", obd_prd_pkg::SLOT_SPEED, obd_prd_pkg::SLOT_SPEED,
			1, 1'b0, 16'h0000, 0);
		// odd alignment, trailing digits and a second prefix are ignored
		add_row("9410Fab41", obd_prd_pkg::SLOT_AIR_TEMP, obd_prd_pkg::SLOT_AIR_TEMP,
			0, 1'b0, 16'h0000, 0);
		add_row("41 04 80 4104", obd_prd_pkg::SLOT_LOAD, obd_prd_pkg::SLOT_LOAD,
			0, 1'b0, 16'h0000, 0);
		// slot switches on the final word, digit count no longer fits
		add_row("410455", obd_prd_pkg::SLOT_LOAD, obd_prd_pkg::SLOT_RPM,
			0, 1'b0, 16'h0000, 0);
		add_row("41 0c 1a f8\r", obd_prd_pkg::SLOT_RPM, obd_prd_pkg::SLOT_RPM,
			0, 1'b0, 16'h0000, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			typed.found = row.found;
			typed.raw   = row.raw;
			typed.val   = 23'(row.val);
			n = row.text.len();
			for (int k = 0; k < n; k++)
				send_char(row.text[k], (k == n - 1) ? row.slot_at_last : row.slot,
					k == n - 1, row.typed, typed);
		end

		n = words_sent;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  hold_seq++; end
				1: begin send_idle_pct = 51; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 51; end
				default: begin send_idle_pct = 13; stall_pct = 13; end
			endcase
			while (words_sent - n < (phase + 1) * RANDOM_ITEMS / 4) send_random_response();
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d responses in %0d words: directed cases, then random text",
			responses, words_sent);
		$display("under four idle/stall mixes and one long output hold; %0d results, %0d found",
			results_seen, found_seen);
		if (errors == 0) begin
			$display("obd_pid_response_decoder_tb: clean");
		end else begin
			$display("%0d failures", errors);
			$display("obd_pid_response_decoder_tb: errors");
		end
		$finish;
	end

endmodule
